// File: hw/rtl/tsm_pkg.sv
// Shared types and request codes of the two-way sorted merge block.
`default_nettype none

package tsm_pkg;

  localparam logic [1:0] REQ_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] REQ_APPEND_SECOND = 2'd1;
  localparam logic [1:0] REQ_MERGE         = 2'd2;

  // Decision of the head compare unit for one merge step.
  typedef struct packed {
    logic take_first;  // emit the first sequence's head
    logic last;        // this step emits the final element
    logic empty;       // both sequences hold nothing
  } tsm_pick_t;

endpackage

`default_nettype wire

// File: hw/rtl/tsm_buf.sv
// Element buffer: one write port and one registered read port.
`default_nettype none

module tsm_buf #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 16,
  parameter int unsigned IdxW  = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IdxW-1:0]  waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [IdxW-1:0]  raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tsm_cmp.sv
// Head compare unit: picks the sequence that supplies the next merged element.
`default_nettype none

module tsm_cmp
  import tsm_pkg::*;
#(
  parameter int unsigned Width = 16,
  parameter int unsigned CntW  = 6
) (
  input  wire logic signed [Width-1:0] head_first_i,
  input  wire logic signed [Width-1:0] head_second_i,
  input  wire logic        [CntW-1:0]  ptr_first_i,
  input  wire logic        [CntW-1:0]  ptr_second_i,
  input  wire logic        [CntW-1:0]  cnt_first_i,
  input  wire logic        [CntW-1:0]  cnt_second_i,
  output tsm_pick_t                    pick_o
);

  logic first_left;
  logic second_left;
  logic first_ends;
  logic second_ends;

  always_comb begin
    first_left  = ptr_first_i < cnt_first_i;
    second_left = ptr_second_i < cnt_second_i;
    first_ends  = (ptr_first_i + CntW'(1)) == cnt_first_i;
    second_ends = (ptr_second_i + CntW'(1)) == cnt_second_i;

    // Ties go to the first sequence, which keeps the merge stable.
    pick_o.take_first = !second_left ||
                        (first_left && (head_first_i <= head_second_i));
    pick_o.last       = pick_o.take_first ? (first_ends && !second_left)
                                          : (second_ends && !first_left);
    pick_o.empty      = (cnt_first_i == '0) && (cnt_second_i == '0);
  end

endmodule

`default_nettype wire

// File: hw/rtl/two_way_sorted_merge.sv
// Top level of the two-way stable merge of two sorted sequences.
// Input transactions carry a request type and a value. Append requests store the
// value at the end of the first or second buffer, one per cycle, and give no
// result; an append to a full buffer is dropped and sets the sticky overflow flag.
// A merge request makes the block busy (in_ready_o low) while a small sequencer
// walks both buffers, compares the two heads in one shared compare unit and emits
// one output transaction per stored element, smaller head first, first sequence
// on ties. The final element carries last_o; a merge of two empty buffers gives a
// single transaction with empty_res_o and last_o set. The sequencer registers one
// result per cycle while the receiver takes them, paced by the registered read port
// of each buffer. The output register holds a result while the receiver stalls,
// and the sequencer waits; appends are not accepted during a merge, but are once
// its final result is registered, also while that result still waits.
// Reset clears both counts, the overflow flag and the output register; buffer
// contents are undefined until written and need no clearing. Both counts return
// to zero after each merge.
`default_nettype none

module two_way_sorted_merge
  import tsm_pkg::*;
#(
  parameter int unsigned SEQ_DEPTH   = 32,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic        [1:0]             req_type_i,
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed      [VALUE_WIDTH-1:0] value_res_o,
  output logic                               from_second_o,
  output logic                               last_o,
  output logic                               empty_res_o,
  output logic                               overflow_o
);

  localparam int unsigned CNT_W = $clog2(SEQ_DEPTH + 1);
  localparam int unsigned IDX_W = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_first_q, cnt_first_d;
  logic [CNT_W-1:0] cnt_second_q, cnt_second_d;
  logic [CNT_W-1:0] ptr_first_q, ptr_first_d;
  logic [CNT_W-1:0] ptr_second_q, ptr_second_d;
  logic             dropped_q, dropped_d;

  logic                          out_valid_q, out_valid_d;
  logic signed [VALUE_WIDTH-1:0] value_res_q, value_res_d;
  logic                          from_second_q, from_second_d;
  logic                          last_q, last_d;
  logic                          empty_res_q, empty_res_d;
  logic                          overflow_q, overflow_d;

  logic                   in_accept;
  logic                   out_free;
  logic                   we_first;
  logic                   we_second;
  logic                   re_first;
  logic                   re_second;
  logic [VALUE_WIDTH-1:0] head_first;
  logic [VALUE_WIDTH-1:0] head_second;
  tsm_pick_t              pick;

  // Buffers are read at the next pointer whenever it lies inside the buffer, so the
  // registered read data holds the current head of each sequence.
  tsm_buf #(
    .Depth (SEQ_DEPTH),
    .Width (VALUE_WIDTH),
    .IdxW  (IDX_W)
  ) u_buf_first (
    .clk_i   (clk_i),
    .we_i    (we_first),
    .waddr_i (cnt_first_q[IDX_W-1:0]),
    .wdata_i (value_i),
    .re_i    (re_first),
    .raddr_i (ptr_first_d[IDX_W-1:0]),
    .rdata_o (head_first)
  );

  tsm_buf #(
    .Depth (SEQ_DEPTH),
    .Width (VALUE_WIDTH),
    .IdxW  (IDX_W)
  ) u_buf_second (
    .clk_i   (clk_i),
    .we_i    (we_second),
    .waddr_i (cnt_second_q[IDX_W-1:0]),
    .wdata_i (value_i),
    .re_i    (re_second),
    .raddr_i (ptr_second_d[IDX_W-1:0]),
    .rdata_o (head_second)
  );

  tsm_cmp #(
    .Width (VALUE_WIDTH),
    .CntW  (CNT_W)
  ) u_cmp (
    .head_first_i  (head_first),
    .head_second_i (head_second),
    .ptr_first_i   (ptr_first_q),
    .ptr_second_i  (ptr_second_q),
    .cnt_first_i   (cnt_first_q),
    .cnt_second_i  (cnt_second_q),
    .pick_o        (pick)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Skip reads past the end of a buffer; such a head is never used.
  assign re_first  = ptr_first_d < CNT_W'(SEQ_DEPTH);
  assign re_second = ptr_second_d < CNT_W'(SEQ_DEPTH);

  always_comb begin
    state_d       = state_q;
    cnt_first_d   = cnt_first_q;
    cnt_second_d  = cnt_second_q;
    ptr_first_d   = ptr_first_q;
    ptr_second_d  = ptr_second_q;
    dropped_d     = dropped_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    value_res_d   = value_res_q;
    from_second_d = from_second_q;
    last_d        = last_q;
    empty_res_d   = empty_res_q;
    overflow_d    = overflow_q;
    we_first      = 1'b0;
    we_second     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (req_type_i)
            REQ_APPEND_FIRST: begin
              if (cnt_first_q == CNT_W'(SEQ_DEPTH)) begin
                dropped_d = 1'b1;
              end else begin
                we_first    = 1'b1;
                cnt_first_d = cnt_first_q + CNT_W'(1);
              end
            end
            REQ_APPEND_SECOND: begin
              if (cnt_second_q == CNT_W'(SEQ_DEPTH)) begin
                dropped_d = 1'b1;
              end else begin
                we_second    = 1'b1;
                cnt_second_d = cnt_second_q + CNT_W'(1);
              end
            end
            REQ_MERGE: begin
              state_d = ST_EMIT;
            end
            default: begin
              // The unused request code is ignored.
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          overflow_d  = dropped_q;
          if (pick.empty) begin
            value_res_d   = '0;
            from_second_d = 1'b0;
            last_d        = 1'b1;
            empty_res_d   = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            empty_res_d   = 1'b0;
            last_d        = pick.last;
            from_second_d = !pick.take_first;
            if (pick.take_first) begin
              value_res_d = head_first;
              ptr_first_d = ptr_first_q + CNT_W'(1);
            end else begin
              value_res_d  = head_second;
              ptr_second_d = ptr_second_q + CNT_W'(1);
            end
            if (pick.last) begin
              cnt_first_d  = '0;
              cnt_second_d = '0;
              ptr_first_d  = '0;
              ptr_second_d = '0;
              state_d      = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_first_q   <= '0;
      cnt_second_q  <= '0;
      ptr_first_q   <= '0;
      ptr_second_q  <= '0;
      dropped_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      value_res_q   <= '0;
      from_second_q <= 1'b0;
      last_q        <= 1'b0;
      empty_res_q   <= 1'b0;
      overflow_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_first_q   <= cnt_first_d;
      cnt_second_q  <= cnt_second_d;
      ptr_first_q   <= ptr_first_d;
      ptr_second_q  <= ptr_second_d;
      dropped_q     <= dropped_d;
      out_valid_q   <= out_valid_d;
      value_res_q   <= value_res_d;
      from_second_q <= from_second_d;
      last_q        <= last_d;
      empty_res_q   <= empty_res_d;
      overflow_q    <= overflow_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_res_o   = value_res_q;
  assign from_second_o = from_second_q;
  assign last_o        = last_q;
  assign empty_res_o   = empty_res_q;
  assign overflow_o    = overflow_q;

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the two-way sorted merge block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsm_pkg::*;

  localparam int unsigned SEQ_DEPTH   = 32;
  localparam int unsigned VALUE_WIDTH = 16;

  // Request code 3 has no meaning; the block must ignore it.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // An idle stretch reaching this length, in which neither side moves a transaction, ends the run.
  localparam int unsigned WATCHDOG_CYCLES = 4000;
  // Cycles allowed after the last result before the verdict.
  localparam int unsigned SETTLE_CYCLES = 10;

  // One merged element as the receiver sees it.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   from_second;
    logic                   is_last;
    logic                   is_empty;
    logic                   overflow;
  } merge_res_t;

  // One row of the directed script. When has_res is set, the row is a merge
  // whose single result can be read off directly and is used as typed.
  typedef struct packed {
    logic [1:0]             req;
    logic [VALUE_WIDTH-1:0] val;
    logic                   has_res;
    merge_res_t             res;
  } script_row_t;

  localparam merge_res_t NO_RES      = '0;
  localparam merge_res_t EMPTY_CLEAN = '{16'h0000, 1'b0, 1'b1, 1'b1, 1'b0};

  localparam int DIR_ROWS = 24;

  // Directed opening: empty merges, single-element merges at both extremes,
  // the unused request code, a cross at the extremes, ties between the two
  // sequences, an unsorted first sequence, a merge where only the second
  // sequence holds data, and alternating bit patterns in the values.
  localparam script_row_t DIRECTED_SCRIPT [DIR_ROWS] = '{
    '{REQ_MERGE,         16'h0000, 1'b1, EMPTY_CLEAN},
    '{REQ_APPEND_FIRST,  16'h8000, 1'b0, NO_RES},
    '{REQ_MERGE,         16'hffff, 1'b1, '{16'h8000, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{REQ_APPEND_SECOND, 16'h7fff, 1'b0, NO_RES},
    '{REQ_MERGE,         16'h0000, 1'b1, '{16'h7fff, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{REQ_UNUSED,        16'h5555, 1'b0, NO_RES},
    '{REQ_MERGE,         16'haaaa, 1'b1, EMPTY_CLEAN},
    '{REQ_APPEND_FIRST,  16'h7fff, 1'b0, NO_RES},
    '{REQ_APPEND_SECOND, 16'h8000, 1'b0, NO_RES},
    '{REQ_MERGE,         16'h0000, 1'b0, NO_RES},
    '{REQ_APPEND_FIRST,  16'h0005, 1'b0, NO_RES},
    '{REQ_APPEND_SECOND, 16'h0005, 1'b0, NO_RES},
    '{REQ_APPEND_FIRST,  16'h0005, 1'b0, NO_RES},
    '{REQ_APPEND_SECOND, 16'h0005, 1'b0, NO_RES},
    '{REQ_MERGE,         16'h0000, 1'b0, NO_RES},
    '{REQ_APPEND_FIRST,  16'hffff, 1'b0, NO_RES},
    '{REQ_APPEND_FIRST,  16'hfffd, 1'b0, NO_RES},
    '{REQ_APPEND_SECOND, 16'hfffe, 1'b0, NO_RES},
    '{REQ_MERGE,         16'h0000, 1'b0, NO_RES},
    '{REQ_APPEND_SECOND, 16'h5555, 1'b0, NO_RES},
    '{REQ_APPEND_SECOND, 16'haaaa, 1'b0, NO_RES},
    '{REQ_MERGE,         16'h0000, 1'b0, NO_RES},
    '{REQ_UNUSED,        16'hffff, 1'b0, NO_RES},
    '{REQ_MERGE,         16'h0000, 1'b1, EMPTY_CLEAN}
  };

  // Clock, reset and every block input start at a known value.
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic [1:0]             req_type_i  = REQ_UNUSED;
  logic [VALUE_WIDTH-1:0] value_i     = '0;
  logic                   out_ready_i = 1'b0;

  logic                   in_ready_o;
  logic                   out_valid_o;
  logic [VALUE_WIDTH-1:0] value_res_o;
  logic                   from_second_o;
  logic                   last_o;
  logic                   empty_res_o;
  logic                   overflow_o;

  // Typed expectation that travels with the input transaction it belongs to.
  logic       typed_valid  = 1'b0;
  merge_res_t typed_result = '0;

  // Shadow copy of the block's buffers and flags.
  logic [VALUE_WIDTH-1:0] first_buf  [SEQ_DEPTH];
  logic [VALUE_WIDTH-1:0] second_buf [SEQ_DEPTH];
  int unsigned            first_len  = 0;
  int unsigned            second_len = 0;
  logic                   dropped    = 1'b0;

  // Merged elements still owed by the block, oldest first.
  merge_res_t pending_merged [$];

  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent  = 0;
  bit          in_quiet    = 1'b0;

  two_way_sorted_merge #(
    .SEQ_DEPTH   (SEQ_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_res_o   (value_res_o),
    .from_second_o (from_second_o),
    .last_o        (last_o),
    .empty_res_o   (empty_res_o),
    .overflow_o    (overflow_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Applies one accepted request to the shadow state and queues the merged
  // elements it causes. Appends beyond the buffer depth are lost and latch the
  // sticky overflow flag. A merge walks both buffers, taking the first
  // sequence's head on a signed compare that favors it on ties, then drains
  // whatever remains. An empty merge still yields one marked result.
  function automatic void track_request(logic [1:0] req, logic [VALUE_WIDTH-1:0] val,
                                        logic use_typed, merge_res_t typed);
    merge_res_t  produced [$];
    merge_res_t  r;
    int unsigned a;
    int unsigned b;
    logic        take_first;
    a = 0;
    b = 0;
    case (req)
      REQ_APPEND_FIRST: begin
        if (first_len >= SEQ_DEPTH) begin
          dropped = 1'b1;
        end else begin
          first_buf[first_len] = val;
          first_len++;
        end
      end
      REQ_APPEND_SECOND: begin
        if (second_len >= SEQ_DEPTH) begin
          dropped = 1'b1;
        end else begin
          second_buf[second_len] = val;
          second_len++;
        end
      end
      REQ_MERGE: begin
        if (first_len + second_len == 0) begin
          r = '{'0, 1'b0, 1'b1, 1'b1, dropped};
          produced.push_back(r);
        end
        while (a < first_len || b < second_len) begin
          if (a >= first_len) take_first = 1'b0;
          else if (b >= second_len) take_first = 1'b1;
          else take_first = $signed(first_buf[a]) <= $signed(second_buf[b]);
          r.value       = take_first ? first_buf[a] : second_buf[b];
          r.from_second = !take_first;
          if (take_first) a++;
          else b++;
          r.is_last  = (a + b == first_len + second_len);
          r.is_empty = 1'b0;
          r.overflow = dropped;
          produced.push_back(r);
        end
        first_len  = 0;
        second_len = 0;
      end
      default: ;
    endcase
    if (use_typed) begin
      // Directed rows carry their one result typed in; the shadow state has
      // already moved on above, so the two stay in step.
      if (produced.size() != 1) begin
        $error("directed merge: expected one result, shadow state gives %0d",
               produced.size());
        fail_count++;
      end
      pending_merged.push_back(typed);
    end else begin
      foreach (produced[i]) pending_merged.push_back(produced[i]);
    end
  endfunction

  // Sampling happens at the rising edge, before the block's registers update,
  // so every accepted transaction on either side is seen with its own payload.
  always @(posedge clk_i) begin
    merge_res_t due;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        track_request(req_type_i, value_i, typed_valid, typed_result);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_merged.size() == 0) begin
          $error("unexpected result: value_res %0d from_second %0b last %0b",
                 $signed(value_res_o), from_second_o, last_o);
          fail_count++;
        end else begin
          due = pending_merged.pop_front();
          if (value_res_o !== due.value) begin
            $error("value_res: expected %0d, got %0d", $signed(due.value),
                   $signed(value_res_o));
            fail_count++;
          end
          if (from_second_o !== due.from_second) begin
            $error("from_second: expected %0b, got %0b", due.from_second, from_second_o);
            fail_count++;
          end
          if (last_o !== due.is_last) begin
            $error("last: expected %0b, got %0b", due.is_last, last_o);
            fail_count++;
          end
          if (empty_res_o !== due.is_empty) begin
            $error("empty_res: expected %0b, got %0b", due.is_empty, empty_res_o);
            fail_count++;
          end
          if (overflow_o !== due.overflow) begin
            $error("overflow: expected %0b, got %0b", due.overflow, overflow_o);
            fail_count++;
          end
        end
      end
    end
    // The watchdog only counts edges at which neither side moved a transaction.
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receiver: bursts of readiness broken by stalls, with some long bursts that
  // never stall at all. Ready is only lowered when the stall has a length, so
  // it never gets two assignments in one time step.
  initial begin
    int unsigned hold;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 9) < 2) begin
        hold  = $urandom_range(20, 80);
        stall = 0;
      end else begin
        hold  = $urandom_range(1, 6);
        stall = gap_cycles();
      end
      out_ready_i <= 1'b1;
      repeat (hold) @(posedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Presents one input transaction and holds it until accepted, then idles
  // for a random gap unless the current batch is a quiet one.
  task automatic send(logic [1:0] req, logic [VALUE_WIDTH-1:0] val,
                      logic use_typed, merge_res_t typed);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    value_i      <= val;
    typed_valid  <= use_typed;
    typed_result <= typed;
    do @(posedge clk_i); while (!in_ready_o);
    if (req != REQ_UNUSED) items_sent++;
    gap = in_quiet ? 0 : gap_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender back until the block has delivered everything it owes.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_merged.size() != 0);
  endtask

  // Element values: occasional extremes, a narrow band around zero when ties
  // are wanted, otherwise the full signed range.
  function automatic int pick_value(bit narrow);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (narrow) return int'($urandom_range(0, 8)) - 4;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Loads two runs with the appends of both sides interleaved at random, then
  // merges. Runs are sorted unless a broken sequence is wanted, and a stray
  // unused request now and then lands in the middle.
  task automatic run_batch(int unsigned n_first, int unsigned n_second,
                           bit sorted_runs, bit narrow);
    int          runs [2][40];
    int unsigned lens [2];
    int unsigned pos  [2];
    int          held;
    int          k;
    int unsigned side;
    lens[0] = n_first;
    lens[1] = n_second;
    for (int s = 0; s < 2; s++) begin
      pos[s] = 0;
      for (int i = 0; i < lens[s]; i++) runs[s][i] = pick_value(narrow);
      if (sorted_runs) begin
        for (int i = 1; i < lens[s]; i++) begin
          held = runs[s][i];
          k    = i - 1;
          while (k >= 0 && runs[s][k] > held) begin
            runs[s][k+1] = runs[s][k];
            k--;
          end
          runs[s][k+1] = held;
        end
      end
    end
    while (pos[0] < lens[0] || pos[1] < lens[1]) begin
      if ($urandom_range(0, 19) == 0) begin
        send(REQ_UNUSED, VALUE_WIDTH'($urandom), 1'b0, NO_RES);
      end
      if (pos[0] >= lens[0]) side = 1;
      else if (pos[1] >= lens[1]) side = 0;
      else side = $urandom_range(0, 1);
      send(side ? REQ_APPEND_SECOND : REQ_APPEND_FIRST,
           VALUE_WIDTH'(runs[side][pos[side]]), 1'b0, NO_RES);
      pos[side]++;
    end
    send(REQ_MERGE, VALUE_WIDTH'($urandom), 1'b0, NO_RES);
  endtask

  function automatic int unsigned run_length();
    if ($urandom_range(0, 7) == 0) return $urandom_range(6, 12);
    return $urandom_range(0, 5);
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send(DIRECTED_SCRIPT[i].req, DIRECTED_SCRIPT[i].val, DIRECTED_SCRIPT[i].has_res,
           DIRECTED_SCRIPT[i].res);
    end

    // Small random batches while the overflow flag is still clear.
    while (items_sent < 70) begin
      in_quiet = ($urandom_range(0, 3) == 0);
      run_batch(run_length(), run_length(), $urandom_range(0, 5) != 0,
                $urandom_range(0, 3) == 0);
      // A back-to-back merge finds both buffers empty.
      if ($urandom_range(0, 5) == 0) send(REQ_MERGE, '0, 1'b0, NO_RES);
    end

    // Let the block run dry, then fill the first buffer to exactly its depth.
    in_quiet = 1'b0;
    wait_drained();
    run_batch(SEQ_DEPTH, $urandom_range(0, 2), 1'b1, 1'b0);

    // Overfill both buffers: the extra appends are dropped, the flag latches,
    // and the merge carries the largest result count the block can give.
    in_quiet = ($urandom_range(0, 1) == 0);
    run_batch(SEQ_DEPTH + $urandom_range(1, 2), SEQ_DEPTH + 1, 1'b1, 1'b0);

    // The flag stays set across later merges, including an empty one.
    in_quiet = 1'b0;
    run_batch($urandom_range(1, 3), $urandom_range(0, 3), 1'b1, 1'b1);
    send(REQ_MERGE, '0, 1'b0, NO_RES);

    in_valid_i <= 1'b0;
    while (pending_merged.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_merged.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
